/* src/dht_pkg.sv */
// Shared types and constants for the DHT11 read sequencer and decoder.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package dht_pkg;

  localparam int unsigned FrameBits   = 40;
  localparam int unsigned FramePulses = FrameBits + 1;
  localparam int unsigned CountW      = 6;
  localparam int unsigned TickW       = 8;
  localparam int unsigned WidthW      = 16;
  localparam int unsigned LevelW      = 7;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [TickW-1:0] TickMax = '1;

  localparam logic [WidthW-1:0] BitThresholdRst = 16'd45;
  localparam logic [LevelW-1:0] TempLevelRst    = 7'd35;
  localparam logic [LevelW-1:0] HumidLevelRst   = 7'd70;
  localparam logic [TickW-1:0]  StartTicksRst   = 8'd25;
  localparam logic [TickW-1:0]  TimeoutTicksRst = 8'd50;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_PULSE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIT_THRESHOLD = 3'd0,
    CFG_TEMP_LEVEL    = 3'd1,
    CFG_HUMID_LEVEL   = 3'd2,
    CFG_START_TICKS   = 3'd3,
    CFG_TIMEOUT_TICKS = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_START   = 3'b010,
    PH_CAPTURE = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [WidthW-1:0] pulse_width;
  } in_t;

  typedef struct packed {
    logic       line_drive_low;
    logic       capturing;
    logic       reading_done;
    logic       timed_out;
    logic       checksum_ok;
    logic [7:0] humidity;
    logic [7:0] temperature;
    logic       temp_over;
    logic       humid_over;
  } out_t;

  typedef struct packed {
    logic [WidthW-1:0] bit_threshold;
    logic [LevelW-1:0] temp_alarm_level;
    logic [LevelW-1:0] humid_alarm_level;
    logic [TickW-1:0]  start_ticks;
    logic [TickW-1:0]  timeout_ticks;
  } cfg_t;

endpackage

`default_nettype wire

/* src/dht_cfg_regs.sv */
// Configuration register file of the DHT11 sequencer.
// Depends on dht_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module dht_cfg_regs
  import dht_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BIT_THRESHOLD: cfg_d.bit_threshold     = cfg_data_i[WidthW-1:0];
        CFG_TEMP_LEVEL:    cfg_d.temp_alarm_level  = cfg_data_i[LevelW-1:0];
        CFG_HUMID_LEVEL:   cfg_d.humid_alarm_level = cfg_data_i[LevelW-1:0];
        CFG_START_TICKS:   cfg_d.start_ticks       = cfg_data_i[TickW-1:0];
        CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks     = cfg_data_i[TickW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_threshold     <= BitThresholdRst;
      cfg_q.temp_alarm_level  <= TempLevelRst;
      cfg_q.humid_alarm_level <= HumidLevelRst;
      cfg_q.start_ticks       <= StartTicksRst;
      cfg_q.timeout_ticks     <= TimeoutTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/dht_core.sv */
// Read state of the DHT11 sequencer and its update on each step: phase, tick
// count, pulse count, frame shift register, decoded readings and alarms.
// Depends on dht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dht_core
  import dht_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire in_t  item_i,
  input  wire cfg_t cfg_i,
  output out_t      res_o
);

  phase_e               phase_q, phase_d;
  logic [TickW-1:0]     elapsed_q, elapsed_d;
  logic [CountW-1:0]    count_q, count_d;
  logic [FrameBits-1:0] frame_q, frame_d;
  logic [7:0]           humid_q, humid_d;
  logic [7:0]           temp_q, temp_d;
  logic                 temp_flag_q, temp_flag_d;
  logic                 humid_flag_q, humid_flag_d;

  logic [TickW-1:0]     elapsed_inc;
  logic [CountW-1:0]    count_inc;
  logic [FrameBits-1:0] frame_shift;
  logic                 data_bit;
  logic [7:0]           byte_sum;
  logic                 frame_ok;
  logic                 done;
  logic                 tout;

  assign elapsed_inc = (elapsed_q == TickMax) ? elapsed_q : elapsed_q + 1'b1;
  assign count_inc   = count_q + 1'b1;
  assign data_bit    = item_i.pulse_width > cfg_i.bit_threshold;
  // The first captured pulse is the sensor's response, not a data bit.
  assign frame_shift = (count_q != '0) ? {frame_q[FrameBits-2:0], data_bit} : frame_q;
  assign byte_sum    = frame_shift[39:32] + frame_shift[31:24]
                     + frame_shift[23:16] + frame_shift[15:8];
  assign frame_ok    = (byte_sum == frame_shift[7:0]) && (frame_shift[7:0] != 8'd0);

  always_comb begin
    phase_d      = phase_q;
    elapsed_d    = elapsed_q;
    count_d      = count_q;
    frame_d      = frame_q;
    humid_d      = humid_q;
    temp_d       = temp_q;
    temp_flag_d  = temp_flag_q;
    humid_flag_d = humid_flag_q;
    done         = 1'b0;
    tout         = 1'b0;

    case (item_i.command)
      CMD_TICK: begin
        if (phase_q != PH_IDLE) begin
          elapsed_d = elapsed_inc;
          if (phase_q == PH_START && elapsed_inc > cfg_i.start_ticks) begin
            phase_d = PH_CAPTURE;
          end
          // Abort can follow the move to capture on the same tick.
          if (elapsed_inc > cfg_i.timeout_ticks) begin
            phase_d = PH_IDLE;
            count_d = '0;
            frame_d = '0;
            tout    = 1'b1;
          end
        end
      end
      CMD_START: begin
        if (phase_q == PH_IDLE) begin
          phase_d   = PH_START;
          elapsed_d = '0;
          count_d   = '0;
          frame_d   = '0;
        end
      end
      CMD_PULSE: begin
        if (phase_q == PH_CAPTURE) begin
          frame_d = frame_shift;
          count_d = count_inc;
          if (count_inc >= CountW'(FramePulses)) begin
            done         = 1'b1;
            humid_d      = frame_ok ? frame_shift[39:32] : 8'd0;
            temp_d       = frame_ok ? frame_shift[23:16] : 8'd0;
            humid_flag_d = humid_d > {1'b0, cfg_i.humid_alarm_level};
            temp_flag_d  = temp_d > {1'b0, cfg_i.temp_alarm_level};
            phase_d      = PH_IDLE;
            count_d      = '0;
            frame_d      = '0;
          end
        end
      end
      default: begin
        // Unused command: hold everything.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      elapsed_q    <= '0;
      count_q      <= '0;
      frame_q      <= '0;
      humid_q      <= '0;
      temp_q       <= '0;
      temp_flag_q  <= 1'b0;
      humid_flag_q <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      elapsed_q    <= elapsed_d;
      count_q      <= count_d;
      frame_q      <= frame_d;
      humid_q      <= humid_d;
      temp_q       <= temp_d;
      temp_flag_q  <= temp_flag_d;
      humid_flag_q <= humid_flag_d;
    end
  end

  always_comb begin
    res_o.line_drive_low = phase_d == PH_START;
    res_o.capturing      = phase_d == PH_CAPTURE;
    res_o.reading_done   = done;
    res_o.timed_out      = tout;
    res_o.checksum_ok    = done & frame_ok;
    res_o.humidity       = humid_d;
    res_o.temperature    = temp_d;
    res_o.temp_over      = temp_flag_d;
    res_o.humid_over     = humid_flag_d;
  end

endmodule

`default_nettype wire

/* src/dht11_read_sequencer_decoder_top.sv */
// Top level of the DHT11 read sequencer and frame decoder.
// Depends on dht_pkg, dht_cfg_regs and dht_core.
//
// Usage:
//   Input channel in_valid_i / in_ready_o / in_i carries one command beat:
//   a time tick, a start request or a captured pulse width. Each beat gives
//   exactly one result beat on out_valid_o / out_ready_i / out_o with the
//   line drive, capture enable, frame status and the stored readings.
//   A beat is registered at acceptance; once the output register is free or
//   draining, it updates the read state and lands in the output register at
//   the same clock edge. One beat is taken every cycle while the receiver
//   does not stall; the state update between the two registers is
//   combinational.
//   When the receiver stalls, the output register holds its beat and the
//   input register holds one more, after which in_ready_o drops.
//   Configuration writes on cfg_we_i / cfg_idx_i / cfg_data_i take effect
//   at the next edge and belong to idle periods; unknown indexes are
//   ignored. Reset (rst_ni low, asynchronous) empties both registers, sets
//   the phase idle, clears readings and alarms and loads the default
//   configuration.
`timescale 1ns / 1ps
`default_nettype none

module dht11_read_sequencer_decoder_top
  import dht_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_t                 in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_t                     out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;
  out_t res;

  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q;
  logic advance;

  dht_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the held beat when the output register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  dht_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire
